/* hw/rtl/vcd_pkg.sv */
// vcd_pkg: shared types, codes and denomination tables of the vending change dispenser
// no dependencies; imported by vcd_cell, vcd_chain, vcd_emit, vending_change_dispenser and the bench

package vcd_pkg;

  // field widths
  localparam int FUNC_W     = 2;
  localparam int CODE_W     = 8;
  localparam int AMOUNT_W   = 16;
  localparam int PRICE_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int FACE_W     = 7;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;

  // credit and walk sizing
  localparam int CREDIT_WIDTH       = 24;
  localparam int DENOMINATION_COUNT = 6;
  localparam int DENOM_SLOTS        = 6;
  localparam int NUM_CELLS          = 2 * DENOM_SLOTS;
  localparam int CELL_IDX_W         = $clog2(NUM_CELLS);
  localparam int CENTS_W            = 14;
  localparam int RECIP_W            = CREDIT_WIDTH + 1;
  localparam int PROD_W             = 2 * CREDIT_WIDTH + 1;
  localparam int TPROD_W            = CREDIT_WIDTH + CENTS_W;
  localparam int COUNT_MAX          = (1 << COUNT_W) - 1;
  localparam int NOTE_UNIT          = 100;
  localparam int ADD_W              = AMOUNT_W + 7;
  localparam int SUM_W              = ((CREDIT_WIDTH > ADD_W) ? CREDIT_WIDTH : ADD_W) + 1;

  localparam logic [CREDIT_WIDTH-1:0] CREDIT_MAX = '1;
  localparam logic [63:0] ONE_SHL = 64'd1 << CREDIT_WIDTH;

  // product codes and reset prices
  localparam logic [CODE_W-1:0]  PRODUCT_ONE   = CODE_W'(1);
  localparam logic [CODE_W-1:0]  PRODUCT_TWO   = CODE_W'(2);
  localparam logic [CODE_W-1:0]  PRODUCT_THREE = CODE_W'(3);
  localparam logic [PRICE_W-1:0] PRICE_ONE_RST   = PRICE_W'(430);
  localparam logic [PRICE_W-1:0] PRICE_TWO_RST   = PRICE_W'(270);
  localparam logic [PRICE_W-1:0] PRICE_THREE_RST = PRICE_W'(143);

  typedef enum logic [FUNC_W-1:0] {
    F_SELECT = 2'd0,
    F_INSERT = 2'd1,
    F_FINISH = 2'd2,
    F_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ITEM    = 2'd0,
    ST_NONE    = 2'd1,
    ST_BADPROD = 2'd2,
    ST_SHORT   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRICE_ONE   = 2'd0,
    CFG_PRICE_TWO   = 2'd1,
    CFG_PRICE_THREE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_e;

  // notes first (face in units of 100 cents), then coins (face in cents)
  localparam int unsigned FACE [NUM_CELLS] = '{100, 50, 20, 10, 5, 2, 100, 50, 25, 10, 5, 1};
  localparam int unsigned CENTS [NUM_CELLS] =
    '{10000, 5000, 2000, 1000, 500, 200, 100, 50, 25, 10, 5, 1};
  localparam int unsigned SAT_CENTS [NUM_CELLS] = '{
    2047 * 10000, 2047 * 5000, 2047 * 2000, 2047 * 1000, 2047 * 500, 2047 * 200,
    2047 * 100, 2047 * 50, 2047 * 25, 2047 * 10, 2047 * 5, 2047 * 1};

  // floor(2^CREDIT_WIDTH / cents): quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP [NUM_CELLS] = '{
    RECIP_W'(ONE_SHL / 64'd10000), RECIP_W'(ONE_SHL / 64'd5000),
    RECIP_W'(ONE_SHL / 64'd2000),  RECIP_W'(ONE_SHL / 64'd1000),
    RECIP_W'(ONE_SHL / 64'd500),   RECIP_W'(ONE_SHL / 64'd200),
    RECIP_W'(ONE_SHL / 64'd100),   RECIP_W'(ONE_SHL / 64'd50),
    RECIP_W'(ONE_SHL / 64'd25),    RECIP_W'(ONE_SHL / 64'd10),
    RECIP_W'(ONE_SHL / 64'd5),     RECIP_W'(ONE_SHL / 64'd1)};

  // link between neighboring cells
  typedef struct packed {
    logic                    valid;
    logic [CREDIT_WIDTH-1:0] rem;
  } chain_t;

  typedef logic [NUM_CELLS-1:0][COUNT_W-1:0] count_row_t;

  typedef struct packed {
    status_e            status;
    logic               is_note;
    logic [FACE_W-1:0]  face;
    logic [COUNT_W-1:0] count;
  } ent_t;

  typedef ent_t [NUM_CELLS-1:0] ent_row_t;

  typedef struct packed {
    logic                 valid;
    logic [NUM_CELLS-1:0] mask;
    ent_row_t             ent;
  } emit_load_t;

  // a cell takes part in the walk only within the first DENOMINATION_COUNT of its table
  function automatic logic cell_used(input logic [CELL_IDX_W-1:0] idx);
    logic lo;
    lo = idx < CELL_IDX_W'(DENOM_SLOTS);
    if (lo) begin
      return idx < CELL_IDX_W'(DENOMINATION_COUNT);
    end
    return (idx - CELL_IDX_W'(DENOM_SLOTS)) < CELL_IDX_W'(DENOMINATION_COUNT);
  endfunction

endpackage

/* hw/rtl/vending_change_dispenser.sv */
// vending_change_dispenser: credit, product checks and greedy change walk (top level)
// depends on vcd_pkg, vcd_chain (vcd_cell) and vcd_emit
//
//   port group   direction  handshake                 carries
//   cfg          in         cfg_we_i                  cfg_index_i, cfg_data_i (prices)
//   in           in         in_valid_i / in_ready_o   func, product_code, is_note, amount
//   out          out        out_valid_o / out_ready_i status, change_is_note, denomination,
//                                                     count, last
//
// select, insert and no-op requests are taken in idle and leave the block idle.
// a failed finish loads its status result into the queue, which hands it to the output register.
// a paid finish registers the remainder and walks the 12-cell row (three stages per denomination),
// then the queue shifts one table slot per cycle until the last used denomination has left it.
// a stalled output holds a used slot at the queue head; in_ready_o stays low until the queue has drained.
// reset loads the three prices, clears credit and selection and empties the queue.

module vending_change_dispenser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vcd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vcd_pkg::PRICE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vcd_pkg::FUNC_W-1:0]    func_i,
  input  logic [vcd_pkg::CODE_W-1:0]    product_code_i,
  input  logic                          is_note_i,
  input  logic [vcd_pkg::AMOUNT_W-1:0]  amount_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vcd_pkg::STATUS_W-1:0]  status_o,
  output logic                          change_is_note_o,
  output logic [vcd_pkg::FACE_W-1:0]    denomination_o,
  output logic [vcd_pkg::COUNT_W-1:0]   count_o,
  output logic                          last_o
);
  import vcd_pkg::*;

  state_e                  state_q, state_d;
  logic [PRICE_W-1:0]      price_one_q, price_two_q, price_three_q;
  logic [CREDIT_WIDTH-1:0] credit_q, credit_d;
  logic [CODE_W-1:0]       chosen_q, chosen_d;
  logic                    start_q, start_d;
  logic [CREDIT_WIDTH-1:0] rem_q, rem_d;

  logic [ADD_W-1:0]        add_val;
  logic [SUM_W-1:0]        sum;
  logic [CREDIT_WIDTH-1:0] credit_sum;
  logic [PRICE_W-1:0]      price_sel;
  logic                    prod_ok, short;

  chain_t                  head;
  count_row_t              counts;
  logic                    chain_done;
  ent_row_t                fail_ent, item_ent;
  logic [NUM_CELLS-1:0]    item_mask;
  emit_load_t              load;
  logic                    emit_busy;

  // credit add, saturating at the top of the credit range
  assign add_val    = is_note_i ? (ADD_W'(amount_i) * ADD_W'(NOTE_UNIT)) : ADD_W'(amount_i);
  assign sum        = SUM_W'(credit_q) + SUM_W'(add_val);
  assign credit_sum = (sum > SUM_W'(CREDIT_MAX)) ? CREDIT_MAX : sum[CREDIT_WIDTH-1:0];

  always_comb begin
    prod_ok   = 1'b1;
    price_sel = '0;
    case (chosen_q)
      PRODUCT_ONE:   price_sel = price_one_q;
      PRODUCT_TWO:   price_sel = price_two_q;
      PRODUCT_THREE: price_sel = price_three_q;
      default:       prod_ok   = 1'b0;
    endcase
  end

  assign short = credit_q < CREDIT_WIDTH'(price_sel);

  always_comb begin
    fail_ent           = '0;
    fail_ent[0].status = prod_ok ? ST_SHORT : ST_BADPROD;
  end

  always_comb begin
    item_ent  = '0;
    item_mask = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      item_ent[i].status  = ST_ITEM;
      item_ent[i].is_note = i < DENOM_SLOTS;
      item_ent[i].face    = FACE_W'(FACE[i]);
      item_ent[i].count   = counts[i];
      item_mask[i]        = counts[i] != '0;
    end
    // nothing paid out: one no-change result
    if (item_mask == '0) begin
      item_ent           = '0;
      item_ent[0].status = ST_NONE;
      item_mask          = NUM_CELLS'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    credit_d   = credit_q;
    chosen_d   = chosen_q;
    start_d    = 1'b0;
    rem_d      = rem_q;
    in_ready_o = 1'b0;
    load.valid = 1'b0;
    load.mask  = NUM_CELLS'(1);
    load.ent   = fail_ent;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_e'(func_i))
            F_SELECT: chosen_d = product_code_i;
            F_INSERT: credit_d = credit_sum;
            F_FINISH: begin
              credit_d = '0;
              if (!prod_ok || short) begin
                load.valid = 1'b1;
                state_d    = S_EMIT;
              end else begin
                start_d = 1'b1;
                rem_d   = credit_q - CREDIT_WIDTH'(price_sel);
                state_d = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (chain_done) begin
          load.valid = 1'b1;
          load.mask  = item_mask;
          load.ent   = item_ent;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!emit_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      price_one_q   <= PRICE_ONE_RST;
      price_two_q   <= PRICE_TWO_RST;
      price_three_q <= PRICE_THREE_RST;
      credit_q      <= '0;
      chosen_q      <= '0;
      start_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      credit_q <= credit_d;
      chosen_q <= chosen_d;
      start_q  <= start_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PRICE_ONE:   price_one_q   <= cfg_data_i;
          CFG_PRICE_TWO:   price_two_q   <= cfg_data_i;
          CFG_PRICE_THREE: price_three_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign head.valid = start_q;
  assign head.rem   = rem_q;

  vcd_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .counts_o (counts),
    .done_o   (chain_done)
  );

  vcd_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .busy_o           (emit_busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .change_is_note_o (change_is_note_o),
    .denomination_o   (denomination_o),
    .count_o          (count_o),
    .last_o           (last_o)
  );

  // the cell row only finishes while a paid request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_done |-> state_q == S_RUN)
    else $error("change walk finished outside of run state");

  // the queue is never reloaded while it still holds results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.valid |-> !emit_busy)
    else $error("result queue reloaded while busy");

  // a non-change result stands alone and carries no denomination
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_ITEM |-> last_o && count_o == '0 && denomination_o == '0)
    else $error("status result is not a single empty result");

  // change results always dispense at least one piece
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ITEM |-> count_o != '0 && denomination_o != '0)
    else $error("change result with no pieces");

endmodule

/* hw/rtl/vcd_cell.sv */
// vcd_cell: one denomination of the change walk, three register stages
// depends on vcd_pkg (tables, chain_t)

module vcd_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [vcd_pkg::CELL_IDX_W-1:0]    cell_idx_i,
  input  vcd_pkg::chain_t                   prev_i,
  output vcd_pkg::chain_t                   next_o,
  output logic [vcd_pkg::COUNT_W-1:0]       count_o
);
  import vcd_pkg::*;

  logic [RECIP_W-1:0]      recip;
  logic [CREDIT_WIDTH-1:0] cents;
  logic [CREDIT_WIDTH-1:0] sat_cents;
  logic                    used;

  logic                    va_q, vb_q, vc_q;
  logic [CREDIT_WIDTH-1:0] rem_a_q, rem_b_q, rem_c_q, rem_c_d;
  logic [PROD_W-1:0]       prod_a_q, prod_a_d;
  logic [CREDIT_WIDTH-1:0] q0_b_q, q0_b_d, t_b_q, t_b_d;
  logic [TPROD_W-1:0]      t_full;
  logic [COUNT_W-1:0]      cnt_q, cnt_d;

  logic [CREDIT_WIDTH-1:0] r0, q;
  logic                    fix, sat;

  assign recip     = RECIP[cell_idx_i];
  assign cents     = CREDIT_WIDTH'(CENTS[cell_idx_i]);
  assign sat_cents = CREDIT_WIDTH'(SAT_CENTS[cell_idx_i]);
  assign used      = cell_used(cell_idx_i);

  // stage a: remainder times reciprocal
  assign prod_a_d = PROD_W'(prev_i.rem) * PROD_W'(recip);

  // stage b: estimated quotient and its value in cents
  assign q0_b_d = prod_a_q[2*CREDIT_WIDTH-1:CREDIT_WIDTH];
  assign t_full = TPROD_W'(q0_b_d) * TPROD_W'(cents);
  assign t_b_d  = t_full[CREDIT_WIDTH-1:0];

  // stage c: correct the estimate by one, then clamp the count; an unused cell passes the remainder on
  always_comb begin
    r0  = rem_b_q - t_b_q;
    fix = r0 >= cents;
    q   = q0_b_q + CREDIT_WIDTH'(fix);
    sat = q > CREDIT_WIDTH'(COUNT_MAX);
    if (!used) begin
      cnt_d   = '0;
      rem_c_d = rem_b_q;
    end else if (sat) begin
      cnt_d   = COUNT_W'(COUNT_MAX);
      rem_c_d = rem_b_q - sat_cents;
    end else begin
      cnt_d   = q[COUNT_W-1:0];
      rem_c_d = fix ? (r0 - cents) : r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= prev_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // payload holds between requests so the tail can read every count at once
  always_ff @(posedge clk_i) begin
    if (prev_i.valid) begin
      rem_a_q  <= prev_i.rem;
      prod_a_q <= prod_a_d;
    end
    if (va_q) begin
      rem_b_q <= rem_a_q;
      q0_b_q  <= q0_b_d;
      t_b_q   <= t_b_d;
    end
    if (vb_q) begin
      rem_c_q <= rem_c_d;
      cnt_q   <= cnt_d;
    end
  end

  assign next_o.valid = vc_q;
  assign next_o.rem   = rem_c_q;
  assign count_o      = cnt_q;

endmodule

/* hw/rtl/vcd_chain.sv */
// vcd_chain: row of denomination cells, notes first then coins
// depends on vcd_pkg and vcd_cell

module vcd_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vcd_pkg::chain_t     head_i,
  output vcd_pkg::count_row_t counts_o,
  output logic                done_o
);
  import vcd_pkg::*;

  chain_t link [NUM_CELLS+1];

  assign link[0] = head_i;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    vcd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_IDX_W'(i)),
      .prev_i     (link[i]),
      .next_o     (link[i+1]),
      .count_o    (counts_o[i])
    );
  end

  // the walk is done when the last coin cell hands on its valid
  assign done_o = link[NUM_CELLS].valid;

endmodule

/* hw/rtl/vcd_emit.sv */
// vcd_emit: result queue that skips unused denominations, plus the output register
// depends on vcd_pkg (ent_t, emit_load_t)

module vcd_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vcd_pkg::emit_load_t          load_i,
  output logic                         busy_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vcd_pkg::STATUS_W-1:0] status_o,
  output logic                         change_is_note_o,
  output logic [vcd_pkg::FACE_W-1:0]   denomination_o,
  output logic [vcd_pkg::COUNT_W-1:0]  count_o,
  output logic                         last_o
);
  import vcd_pkg::*;

  logic [NUM_CELLS-1:0] mask_q, mask_d;
  ent_row_t             ent_q, ent_d;
  logic                 out_valid_q, out_valid_d;
  ent_t                 out_q;
  logic                 last_q;
  logic                 slot_free, push;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    mask_d = mask_q;
    ent_d  = ent_q;
    push   = 1'b0;
    if (load_i.valid) begin
      mask_d = load_i.mask;
      ent_d  = load_i.ent;
    end else if (mask_q != '0) begin
      push = mask_q[0] && slot_free;
      // empty slots shift out without waiting for the sink
      if (!mask_q[0] || slot_free) begin
        mask_d = mask_q >> 1;
        ent_d  = ent_row_t'(ent_q >> $bits(ent_t));
      end
    end
  end

  assign out_valid_d = push || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (push) begin
      out_q  <= ent_q[0];
      last_q <= mask_q[NUM_CELLS-1:1] == '0;
    end
  end

  assign busy_o           = mask_q != '0;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign change_is_note_o = out_q.is_note;
  assign denomination_o   = out_q.face;
  assign count_o          = out_q.count;
  assign last_o           = last_q;

endmodule

/* dv/tb_vending_change_dispenser.sv */
// tb_vending_change_dispenser: self-checking bench for the vending change dispenser
// holds a scoreboard class that predicts credit, product checks and greedy change
// depends on vcd_pkg and vending_change_dispenser

module tb_vending_change_dispenser;
  import vcd_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    status_e            status;
    logic               is_note;
    logic [FACE_W-1:0]  face;
    logic [COUNT_W-1:0] count;
    logic               last;
  } change_t;

  class vend_scoreboard;
    longint unsigned  credit;
    logic [CODE_W-1:0] product;
    longint unsigned  prices [3];
    change_t          owed_change [$];
    int               mismatches;
    int               results_checked;
    int               sessions_closed;

    function void reset_state();
      credit    = 0;
      product   = '0;
      prices[0] = PRICE_ONE_RST;
      prices[1] = PRICE_TWO_RST;
      prices[2] = PRICE_THREE_RST;
    endfunction

    function void set_price(cfg_idx_e idx, logic [PRICE_W-1:0] value);
      prices[int'(idx)] = value;
    endfunction

    function int pending();
      return owed_change.size();
    endfunction

    function void push_status(status_e st);
      change_t c;
      c         = '0;
      c.status  = st;
      c.last    = 1'b1;
      owed_change.push_back(c);
    endfunction

    // greedy walk over the notes, then the coins
    function void settle_session();
      int unsigned     note_face [6];
      int unsigned     coin_face [6];
      longint unsigned price;
      longint unsigned change;
      longint unsigned cents;
      longint unsigned pieces;
      int              paid;
      change_t         c;
      note_face = '{100, 50, 20, 10, 5, 2};
      coin_face = '{100, 50, 25, 10, 5, 1};
      paid = 0;
      sessions_closed++;
      case (product)
        PRODUCT_ONE:   price = prices[0];
        PRODUCT_TWO:   price = prices[1];
        PRODUCT_THREE: price = prices[2];
        default: begin
          credit = 0;
          push_status(ST_BADPROD);
          return;
        end
      endcase
      if (credit < price) begin
        credit = 0;
        push_status(ST_SHORT);
        return;
      end
      change = credit - price;
      credit = 0;
      for (int k = 0; k < 12; k++) begin
        if ((k % 6) >= DENOMINATION_COUNT) continue;
        cents  = (k < 6) ? longint'(note_face[k]) * NOTE_UNIT : longint'(coin_face[k - 6]);
        pieces = change / cents;
        if (pieces == 0) continue;
        if (pieces > COUNT_MAX) pieces = COUNT_MAX;
        change   -= pieces * cents;
        c         = '0;
        c.status  = ST_ITEM;
        c.is_note = (k < 6);
        c.face    = FACE_W'((k < 6) ? note_face[k] : coin_face[k - 6]);
        c.count   = COUNT_W'(pieces);
        owed_change.push_back(c);
        paid++;
      end
      if (paid == 0) begin
        push_status(ST_NONE);
      end else begin
        owed_change[owed_change.size() - 1].last = 1'b1;
      end
    endfunction

    function void note_request(func_e f, logic [CODE_W-1:0] code, logic note,
                               logic [AMOUNT_W-1:0] amt);
      longint unsigned add;
      case (f)
        F_SELECT: product = code;
        F_INSERT: begin
          add    = note ? longint'(amt) * NOTE_UNIT : longint'(amt);
          credit = credit + add;
          if (credit > CREDIT_MAX) credit = CREDIT_MAX;
        end
        F_FINISH: settle_session();
        default: ;
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic note, logic [FACE_W-1:0] face,
                               logic [COUNT_W-1:0] cnt, logic lst);
      change_t want;
      results_checked++;
      if (owed_change.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing owed: status %0d note %0b denom %0d count %0d last %0b",
                   $time, st, note, face, cnt, lst);
        return;
      end
      want = owed_change.pop_front();
      if (want.status != st || want.is_note != note || want.face != face ||
          want.count != cnt || want.last != lst) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: change mismatch: want status %0d note %0b denom %0d count %0d last %0b, got status %0d note %0b denom %0d count %0d last %0b",
                   $time, want.status, want.is_note, want.face, want.count, want.last,
                   st, note, face, cnt, lst);
      end
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [PRICE_W-1:0]    cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i         = '0;
  logic [CODE_W-1:0]     product_code_i = '0;
  logic                  is_note_i      = 1'b0;
  logic [AMOUNT_W-1:0]   amount_i       = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic                  change_is_note_o;
  logic [FACE_W-1:0]     denomination_o;
  logic [COUNT_W-1:0]    count_o;
  logic                  last_o;

  vend_scoreboard sb;
  logic           calm = 1'b0;
  int             cycles = 0;
  int             requests = 0;

  vending_change_dispenser i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .product_code_i   (product_code_i),
    .is_note_i        (is_note_i),
    .amount_i         (amount_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .change_is_note_o (change_is_note_o),
    .denomination_o   (denomination_o),
    .count_o          (count_o),
    .last_o           (last_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // receiver drops ready at random, 12 times in a hundred, unless the calm stretch is on
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("tb_vending_change_dispenser: errors");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, change_is_note_o, denomination_o, count_o, last_o);
  end

  task automatic send_request(input func_e f, input logic [CODE_W-1:0] code,
                              input logic note, input logic [AMOUNT_W-1:0] amt);
    while (!calm && $urandom_range(0, 99) < 12) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    func_i         <= f;
    product_code_i <= code;
    is_note_i      <= note;
    amount_i       <= amt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(f, code, note, amt);
    if (f != F_NOP) requests++;
  endtask

  // let every owed result out, then let the design settle with the input idle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_price(input cfg_idx_e idx, input logic [PRICE_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.set_price(idx, value);
  endtask

  task automatic program_prices(input logic [PRICE_W-1:0] p1, input logic [PRICE_W-1:0] p2,
                                input logic [PRICE_W-1:0] p3);
    set_price(CFG_PRICE_ONE, p1);
    set_price(CFG_PRICE_TWO, p2);
    set_price(CFG_PRICE_THREE, p3);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [AMOUNT_W-1:0] pick_amount(input logic note);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return note ? AMOUNT_W'($urandom_range(0, 20)) : AMOUNT_W'($urandom_range(0, 500));
    if (r < 9) return AMOUNT_W'($urandom);
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  // mostly well-formed sessions with random content, the rest is noise
  task automatic run_sessions(input int budget);
    int                issued;
    int                inserts;
    logic              note;
    logic [CODE_W-1:0] code;
    func_e             f;
    issued = 0;
    while (issued < budget) begin
      if ($urandom_range(0, 99) < 80) begin
        code = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(1, 3));
        // sometimes keep the product from the previous session
        if ($urandom_range(0, 4) != 0) begin
          send_request(F_SELECT, code, 1'($urandom), AMOUNT_W'($urandom));
          issued++;
        end
        inserts = $urandom_range(1, 4);
        repeat (inserts) begin
          note = 1'($urandom);
          send_request(F_INSERT, CODE_W'($urandom), note, pick_amount(note));
          issued++;
        end
        send_request(F_FINISH, CODE_W'($urandom), 1'($urandom), AMOUNT_W'($urandom));
        issued++;
      end else begin
        f = func_e'($urandom_range(0, 3));
        send_request(f, CODE_W'($urandom), 1'($urandom), AMOUNT_W'($urandom));
        if (f != F_NOP) issued++;
      end
    end
  endtask

  initial begin
    sb = new;
    sb.reset_state();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset prices
    send_request(F_FINISH, '0, 1'b0, '0);              // nothing selected yet
    send_request(F_NOP, '1, 1'b1, '1);                 // ignored
    send_request(F_SELECT, '0, 1'b0, '0);
    send_request(F_INSERT, '0, 1'b0, '0);              // zero amount
    send_request(F_FINISH, '0, 1'b0, '0);
    send_request(F_SELECT, '1, 1'b1, '1);
    send_request(F_FINISH, '1, 1'b1, '1);              // code out of range
    send_request(F_SELECT, PRODUCT_ONE, 1'b0, '0);
    send_request(F_INSERT, '0, 1'b0, AMOUNT_W'(430));
    send_request(F_FINISH, '0, 1'b0, '0);              // exact payment
    send_request(F_SELECT, PRODUCT_TWO, 1'b0, '0);
    send_request(F_INSERT, '0, 1'b0, AMOUNT_W'(100));
    send_request(F_FINISH, '0, 1'b0, '0);              // short of the price
    send_request(F_SELECT, PRODUCT_THREE, 1'b0, '0);
    send_request(F_INSERT, '0, 1'b1, '1);
    send_request(F_INSERT, '0, 1'b1, '1);
    send_request(F_INSERT, '0, 1'b1, '1);              // credit saturates here
    send_request(F_INSERT, '0, 1'b0, '1);
    send_request(F_FINISH, '0, 1'b0, '0);              // change from a saturated credit
    send_request(F_SELECT, CODE_W'(4), 1'b0, '0);
    send_request(F_FINISH, '0, 1'b0, '0);
    send_request(F_SELECT, PRODUCT_THREE, 1'b0, '0);
    send_request(F_FINISH, '0, 1'b0, '0);              // short, selection kept
    send_request(F_INSERT, '0, 1'b0, AMOUNT_W'(200));
    send_request(F_FINISH, '0, 1'b0, '0);
    drain();

    program_prices('0, '0, '0);
    run_sessions(35);
    drain();

    calm = 1'b1;
    program_prices('1, '1, '1);
    run_sessions(35);
    drain();
    calm = 1'b0;

    program_prices(PRICE_W'($urandom), PRICE_W'($urandom_range(0, 2000)),
                   PRICE_W'($urandom_range(0, 500)));
    run_sessions(40);
    drain();

    program_prices('0, '1, PRICE_W'($urandom));
    run_sessions(35);
    drain();

    $display("drove %0d requests over five price settings, closed %0d sessions",
             requests, sb.sessions_closed);
    $display("checked %0d change results, %0d mismatches", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_vending_change_dispenser: clean");
    end else begin
      $display("tb_vending_change_dispenser: errors");
    end
    $finish;
  end

endmodule

/* vending_change_dispenser.f */
hw/rtl/vcd_pkg.sv
hw/rtl/vcd_cell.sv
hw/rtl/vcd_chain.sv
hw/rtl/vcd_emit.sv
hw/rtl/vending_change_dispenser.sv
dv/tb_vending_change_dispenser.sv
